// ===== hdl/precharge_contactor_sequencer_top_assert.svh =====
// Assertion macros shared by the precharge contactor sequencer RTL.
// No dependencies; define ASSERT_OFF to drop every assertion.
`ifndef PRECHARGE_CONTACTOR_SEQUENCER_TOP_ASSERT_SVH
`define PRECHARGE_CONTACTOR_SEQUENCER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define PCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define PCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/pcs_pkg.sv =====
// Shared types and constants for the precharge contactor sequencer.
// No dependencies; the RTL modules refer to it by scoped names.
package pcs_pkg;

  localparam int VOLTAGE_WIDTH = 16;
  localparam int RATIO_W       = 10;
  localparam int RATIO_FRAC    = 8;
  localparam int PROD_W        = VOLTAGE_WIDTH + RATIO_W;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_SAFE_RATIO = 1'b0;
  localparam logic [RATIO_W-1:0]   RATIO_RESET    = 10'd230;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_CHARGE     = 3'd1,
    OP_CLOSE      = 3'd2,
    OP_HOLD       = 3'd3,
    OP_FORCE_OPEN = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    MODE_OPEN      = 3'd0,
    MODE_CHARGING  = 3'd1,
    MODE_CHARGED   = 3'd2,
    MODE_PRECHARGE = 3'd3,
    MODE_CLOSED    = 3'd4
  } mode_t;

  typedef struct packed {
    op_t                      op;
    logic [VOLTAGE_WIDTH-1:0] target_level;
    logic [VOLTAGE_WIDTH-1:0] bus_level;
    logic [VOLTAGE_WIDTH-1:0] storage_level;
  } item_t;

  typedef struct packed {
    mode_t mode;
    logic  ess_discharge_closed;
    logic  discharge_closed;
    logic  ess_charge_closed;
    logic  low_side_closed;
    logic  high_side_closed;
    logic  precharge_closed;
  } result_t;

endpackage

// ===== hdl/pcs_in_stage.sv =====
// Input register of the sequencer: captures one transaction per cycle while in_stall is low.
// Depends on pcs_pkg for the item type.
module pcs_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_operation,
  input  logic [pcs_pkg::VOLTAGE_WIDTH-1:0] in_target_level,
  input  logic [pcs_pkg::VOLTAGE_WIDTH-1:0] in_bus_level,
  input  logic [pcs_pkg::VOLTAGE_WIDTH-1:0] in_storage_level,
  input  logic                              down_free,
  output logic                              adv,
  output pcs_pkg::item_t                    item
);

  logic           valid_r;
  logic           valid_nxt;
  pcs_pkg::item_t item_r;
  logic           load;

  // The held item moves on whenever the result register can take it.
  assign adv       = valid_r && down_free;
  assign in_stall  = valid_r && !down_free;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !adv);
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op            <= pcs_pkg::op_t'(in_operation);
      item_r.target_level  <= in_target_level;
      item_r.bus_level     <= in_bus_level;
      item_r.storage_level <= in_storage_level;
    end
  end

endmodule

// ===== hdl/pcs_core.sv =====
// Mode state machine, request flags, bus-safe compare and contactor decode.
// Depends on pcs_pkg and the assertion macro header.
`include "precharge_contactor_sequencer_top_assert.svh"

module pcs_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  pcs_pkg::item_t              item,
  input  logic [pcs_pkg::RATIO_W-1:0] safe_ratio,
  output pcs_pkg::result_t            res
);

  localparam int VW = pcs_pkg::VOLTAGE_WIDTH;
  localparam int PW = pcs_pkg::PROD_W;
  localparam int RF = pcs_pkg::RATIO_FRAC;

  pcs_pkg::mode_t mode_r;
  pcs_pkg::mode_t mode_nxt;
  logic [VW-1:0]  charge_target_r;
  logic [VW-1:0]  charge_target_nxt;
  logic           charge_pending_r;
  logic           charge_pending_nxt;
  logic           close_pending_r;
  logic           close_pending_nxt;
  logic           hold_pending_r;
  logic           hold_pending_nxt;

  logic [PW-1:0]  bus_scaled;
  logic [PW-1:0]  storage_scaled;
  logic           bus_safe;
  logic           reached;
  logic           entered;

  // Bus is safe when bus * 2^RF >= storage * ratio, exact in PW bits.
  assign bus_scaled     = {{(PW-VW-RF){1'b0}}, item.bus_level, {RF{1'b0}}};
  assign storage_scaled = {{(PW-VW){1'b0}}, item.storage_level} *
                          {{(PW-pcs_pkg::RATIO_W){1'b0}}, safe_ratio};
  assign bus_safe       = bus_scaled >= storage_scaled;
  assign reached        = item.storage_level >= charge_target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= pcs_pkg::MODE_OPEN;
      charge_target_r  <= '0;
      charge_pending_r <= 1'b0;
      close_pending_r  <= 1'b0;
      hold_pending_r   <= 1'b0;
    end else begin
      mode_r           <= mode_nxt;
      charge_target_r  <= charge_target_nxt;
      charge_pending_r <= charge_pending_nxt;
      close_pending_r  <= close_pending_nxt;
      hold_pending_r   <= hold_pending_nxt;
    end
  end

  always_comb begin
    mode_nxt           = mode_r;
    charge_target_nxt  = charge_target_r;
    charge_pending_nxt = charge_pending_r;
    close_pending_nxt  = close_pending_r;
    hold_pending_nxt   = hold_pending_r;
    entered            = 1'b0;

    if (adv) begin
      case (item.op)
        pcs_pkg::OP_TICK: begin
          // First matching transition wins.
          unique case (mode_r)
            pcs_pkg::MODE_OPEN: begin
              if (charge_pending_r) begin
                mode_nxt = reached ? pcs_pkg::MODE_CHARGED : pcs_pkg::MODE_CHARGING;
                entered  = 1'b1;
              end
            end
            pcs_pkg::MODE_CHARGING: begin
              if (reached) begin
                mode_nxt = pcs_pkg::MODE_CHARGED;
                entered  = 1'b1;
              end
            end
            pcs_pkg::MODE_CHARGED: begin
              if (charge_pending_r && !reached) begin
                mode_nxt = pcs_pkg::MODE_CHARGING;
                entered  = 1'b1;
              end else if (close_pending_r) begin
                mode_nxt = bus_safe ? pcs_pkg::MODE_CLOSED : pcs_pkg::MODE_PRECHARGE;
                entered  = 1'b1;
              end
            end
            pcs_pkg::MODE_PRECHARGE: begin
              if (hold_pending_r) begin
                mode_nxt = pcs_pkg::MODE_CHARGED;
                entered  = 1'b1;
              end else if (bus_safe) begin
                mode_nxt = pcs_pkg::MODE_CLOSED;
                entered  = 1'b1;
              end
            end
            pcs_pkg::MODE_CLOSED: begin
              if (hold_pending_r) begin
                mode_nxt = pcs_pkg::MODE_CHARGED;
                entered  = 1'b1;
              end
            end
            default: begin
              mode_nxt = pcs_pkg::MODE_OPEN;
              entered  = 1'b1;
            end
          endcase
        end
        pcs_pkg::OP_CHARGE: begin
          if (mode_r inside {pcs_pkg::MODE_OPEN, pcs_pkg::MODE_CHARGING,
                             pcs_pkg::MODE_CHARGED}) begin
            charge_target_nxt  = item.target_level;
            charge_pending_nxt = 1'b1;
          end
        end
        pcs_pkg::OP_CLOSE: begin
          if (mode_r == pcs_pkg::MODE_CHARGED) begin
            close_pending_nxt = 1'b1;
          end
        end
        pcs_pkg::OP_HOLD: begin
          if (mode_r inside {pcs_pkg::MODE_PRECHARGE, pcs_pkg::MODE_CLOSED}) begin
            hold_pending_nxt = 1'b1;
          end
        end
        pcs_pkg::OP_FORCE_OPEN: begin
          mode_nxt = pcs_pkg::MODE_OPEN;
          entered  = 1'b1;
        end
        default: begin
        end
      endcase

      // Drop all requests on entry to a resting mode.
      if (entered && (mode_nxt inside {pcs_pkg::MODE_OPEN, pcs_pkg::MODE_CHARGED,
                                       pcs_pkg::MODE_CLOSED})) begin
        charge_pending_nxt = 1'b0;
        close_pending_nxt  = 1'b0;
        hold_pending_nxt   = 1'b0;
      end
    end
  end

  // Contactor set of the mode after this item.
  always_comb begin
    res      = '0;
    res.mode = mode_nxt;
    case (mode_nxt) inside
      pcs_pkg::MODE_OPEN: begin
        res.ess_discharge_closed = 1'b1;
        res.discharge_closed     = 1'b1;
      end
      pcs_pkg::MODE_CHARGING: begin
        res.discharge_closed  = 1'b1;
        res.ess_charge_closed = 1'b1;
      end
      pcs_pkg::MODE_CHARGED: begin
        res.discharge_closed = 1'b1;
      end
      pcs_pkg::MODE_PRECHARGE: begin
        res.low_side_closed  = 1'b1;
        res.precharge_closed = 1'b1;
      end
      pcs_pkg::MODE_CLOSED: begin
        res.low_side_closed  = 1'b1;
        res.high_side_closed = 1'b1;
      end
      default: begin
      end
    endcase
  end

  `PCS_ASSERT_NEXT(a_force_open_clears, clk, rst_n,
                   adv && item.op == pcs_pkg::OP_FORCE_OPEN,
                   mode_r == pcs_pkg::MODE_OPEN && !charge_pending_r &&
                   !close_pending_r && !hold_pending_r)
  `PCS_ASSERT_NOW(a_hold_mode, clk, rst_n, hold_pending_r,
                  mode_r == pcs_pkg::MODE_PRECHARGE || mode_r == pcs_pkg::MODE_CLOSED)
  `PCS_ASSERT_NOW(a_close_mode, clk, rst_n, close_pending_r,
                  mode_r == pcs_pkg::MODE_CHARGED || mode_r == pcs_pkg::MODE_CHARGING ||
                  mode_r == pcs_pkg::MODE_PRECHARGE)
  `PCS_ASSERT_NEXT(a_idle_holds_state, clk, rst_n, !adv,
                   $stable(mode_r) && $stable(charge_target_r))

endmodule

// ===== hdl/pcs_out_stage.sv =====
// Result register of the sequencer: holds one result until it is taken.
// Depends on pcs_pkg for the result type.
module pcs_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  pcs_pkg::result_t res,
  output logic             down_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_mode,
  output logic             out_ess_discharge_closed,
  output logic             out_discharge_closed,
  output logic             out_ess_charge_closed,
  output logic             out_low_side_closed,
  output logic             out_high_side_closed,
  output logic             out_precharge_closed
);

  logic             valid_r;
  logic             valid_nxt;
  pcs_pkg::result_t res_r;

  // Free when empty or when the held result leaves this cycle.
  assign down_free = !valid_r || !out_stall;
  assign valid_nxt = adv || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid                = valid_r;
  assign out_mode                 = res_r.mode;
  assign out_ess_discharge_closed = res_r.ess_discharge_closed;
  assign out_discharge_closed     = res_r.discharge_closed;
  assign out_ess_charge_closed    = res_r.ess_charge_closed;
  assign out_low_side_closed      = res_r.low_side_closed;
  assign out_high_side_closed     = res_r.high_side_closed;
  assign out_precharge_closed     = res_r.precharge_closed;

endmodule

// ===== hdl/precharge_contactor_sequencer_top.sv =====
// Top level of the precharge contactor sequencer and its register port.
// Depends on pcs_pkg, pcs_in_stage, pcs_core and pcs_out_stage.
//
//  Port group  | Direction | Handshake          | Content
//  ------------+-----------+--------------------+-------------------------------------
//  in_*        | input     | in_valid/in_stall  | operation, target, bus, storage
//  out_*       | output    | out_valid/out_stall| mode and six contactor states
//  p* (APB)    | slave     | psel/penable       | safe_ratio_q8 at byte address 0
//
// One transaction enters per cycle while in_stall is low; it is captured in the input
// register, then the mode logic and bus-safe multiply write its result into the result
// register, which holds it until the consumer takes it. Throughput is one item per
// cycle while out_stall is low, as the mode update needs no extra states.
// Synchronous active-low reset returns the mode to open, clears all requests and the
// charge target, and loads the safe ratio with 230 (0.898 in Q2.8).
// A stall on the result side holds the result register; the input register then
// holds its item and raises in_stall in the same cycle.
module precharge_contactor_sequencer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_operation,
  input  logic [pcs_pkg::VOLTAGE_WIDTH-1:0] in_target_level,
  input  logic [pcs_pkg::VOLTAGE_WIDTH-1:0] in_bus_level,
  input  logic [pcs_pkg::VOLTAGE_WIDTH-1:0] in_storage_level,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_mode,
  output logic                              out_ess_discharge_closed,
  output logic                              out_discharge_closed,
  output logic                              out_ess_charge_closed,
  output logic                              out_low_side_closed,
  output logic                              out_high_side_closed,
  output logic                              out_precharge_closed,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]        paddr,
  input  logic [pcs_pkg::DATA_W-1:0]        pwdata,
  output logic [pcs_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [pcs_pkg::RATIO_W-1:0]   safe_ratio_r;
  logic [pcs_pkg::RATIO_W-1:0]   safe_ratio_nxt;
  logic [pcs_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  logic             adv;
  logic             down_free;
  pcs_pkg::item_t   item;
  pcs_pkg::result_t res;

  // Register port: word index from the byte address, write on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[pcs_pkg::ADDR_W-1:pcs_pkg::ADDR_W-pcs_pkg::REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    safe_ratio_nxt = safe_ratio_r;
    if (wr_en && reg_idx == pcs_pkg::REG_SAFE_RATIO) begin
      safe_ratio_nxt = pwdata[pcs_pkg::RATIO_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pcs_pkg::REG_SAFE_RATIO: prdata = {{(pcs_pkg::DATA_W-pcs_pkg::RATIO_W){1'b0}},
                                         safe_ratio_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_ratio_r <= pcs_pkg::RATIO_RESET;
    end else begin
      safe_ratio_r <= safe_ratio_nxt;
    end
  end

  // Capture the transaction.
  pcs_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_target_level  (in_target_level),
    .in_bus_level     (in_bus_level),
    .in_storage_level (in_storage_level),
    .down_free        (down_free),
    .adv              (adv),
    .item             (item)
  );

  // Advance the mode and decode the contactors.
  pcs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (item),
    .safe_ratio (safe_ratio_r),
    .res        (res)
  );

  // Hold the result until the consumer takes it.
  pcs_out_stage u_out_stage (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .adv                      (adv),
    .res                      (res),
    .down_free                (down_free),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_mode                 (out_mode),
    .out_ess_discharge_closed (out_ess_discharge_closed),
    .out_discharge_closed     (out_discharge_closed),
    .out_ess_charge_closed    (out_ess_charge_closed),
    .out_low_side_closed      (out_low_side_closed),
    .out_high_side_closed     (out_high_side_closed),
    .out_precharge_closed     (out_precharge_closed)
  );

endmodule

// ===== verif/pcs_scoreboard_pkg.sv =====
// Scoreboard class for the precharge contactor sequencer testbench.
// Depends on pcs_pkg for the mode, operation and result types.
package pcs_scoreboard_pkg;
  import pcs_pkg::*;

  localparam int REPORT_LIMIT = 10;

  class contactor_scoreboard;
    mode_t                    mode;
    logic [VOLTAGE_WIDTH-1:0] target;
    bit                       charge_req;
    bit                       close_req;
    bit                       hold_req;
    logic [RATIO_W-1:0]       ratio;
    result_t                  expected_q[$];
    int                       mismatches;
    int                       failures;

    function new();
      mode       = MODE_OPEN;
      target     = '0;
      charge_req = 1'b0;
      close_req  = 1'b0;
      hold_req   = 1'b0;
      ratio      = RATIO_RESET;
      mismatches = 0;
      failures   = 0;
    endfunction

    function void set_ratio(logic [RATIO_W-1:0] value);
      ratio = value;
    endfunction

    // Exact compare: bus * 256 against storage * ratio.
    function bit bus_safe(logic [VOLTAGE_WIDTH-1:0] bus, logic [VOLTAGE_WIDTH-1:0] sto);
      return (64'(bus) << RATIO_FRAC) >= 64'(sto) * 64'(ratio);
    endfunction

    function void enter(mode_t m);
      mode = m;
      if (m == MODE_OPEN || m == MODE_CHARGED || m == MODE_CLOSED) begin
        charge_req = 1'b0;
        close_req  = 1'b0;
        hold_req   = 1'b0;
      end
    endfunction

    function result_t contactor_view(mode_t m);
      result_t r;
      r.mode                 = m;
      r.ess_discharge_closed = (m == MODE_OPEN);
      r.discharge_closed     = (m == MODE_OPEN || m == MODE_CHARGING || m == MODE_CHARGED);
      r.ess_charge_closed    = (m == MODE_CHARGING);
      r.low_side_closed      = (m == MODE_PRECHARGE || m == MODE_CLOSED);
      r.high_side_closed     = (m == MODE_CLOSED);
      r.precharge_closed     = (m == MODE_PRECHARGE);
      return r;
    endfunction

    // At most one transition per tick, first match wins.
    function void apply_tick(logic [VOLTAGE_WIDTH-1:0] bus, logic [VOLTAGE_WIDTH-1:0] sto);
      bit safe;
      bit reached;
      safe    = bus_safe(bus, sto);
      reached = (sto >= target);
      case (mode)
        MODE_OPEN: begin
          if (charge_req && !reached) enter(MODE_CHARGING);
          else if (charge_req && reached) enter(MODE_CHARGED);
        end
        MODE_CHARGING: begin
          if (reached) enter(MODE_CHARGED);
        end
        MODE_CHARGED: begin
          if (charge_req && !reached) enter(MODE_CHARGING);
          else if (close_req && !safe) enter(MODE_PRECHARGE);
          else if (close_req && safe) enter(MODE_CLOSED);
        end
        MODE_PRECHARGE: begin
          if (hold_req) enter(MODE_CHARGED);
          else if (safe) enter(MODE_CLOSED);
        end
        MODE_CLOSED: begin
          if (hold_req) enter(MODE_CHARGED);
        end
        default: enter(MODE_OPEN);
      endcase
    endfunction

    function void note_input(logic [2:0] op, logic [VOLTAGE_WIDTH-1:0] tgt,
                             logic [VOLTAGE_WIDTH-1:0] bus, logic [VOLTAGE_WIDTH-1:0] sto);
      case (op)
        OP_TICK: apply_tick(bus, sto);
        OP_CHARGE: begin
          if (mode == MODE_OPEN || mode == MODE_CHARGING || mode == MODE_CHARGED) begin
            target     = tgt;
            charge_req = 1'b1;
          end
        end
        OP_CLOSE: begin
          if (mode == MODE_CHARGED) close_req = 1'b1;
        end
        OP_HOLD: begin
          if (mode == MODE_PRECHARGE || mode == MODE_CLOSED) hold_req = 1'b1;
        end
        OP_FORCE_OPEN: enter(MODE_OPEN);
        default: ;
      endcase
      expected_q.push_back(contactor_view(mode));
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: mode %0d contactors %b", got.mode, got[5:0]);
        return;
      end
      exp = expected_q.pop_front();
      if (got.mode !== exp.mode ||
          got.ess_discharge_closed !== exp.ess_discharge_closed ||
          got.discharge_closed !== exp.discharge_closed ||
          got.ess_charge_closed !== exp.ess_charge_closed ||
          got.low_side_closed !== exp.low_side_closed ||
          got.high_side_closed !== exp.high_side_closed ||
          got.precharge_closed !== exp.precharge_closed) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected mode %0d contactors %b, got mode %0d contactors %b",
                   exp.mode, exp[5:0], got.mode, got[5:0]);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_precharge_contactor_sequencer_top.sv =====
// Testbench for precharge_contactor_sequencer_top: directed and random transactions
// checked against a mode predictor. Depends on pcs_pkg and pcs_scoreboard_pkg.
module tb_precharge_contactor_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;
  import pcs_scoreboard_pkg::*;

  typedef logic [VOLTAGE_WIDTH-1:0] level_t;

  localparam int              RANDOM_PER_PHASE = 200;
  localparam int              PRESSURE_AFTER   = 150;
  localparam int              PRESSURE_CYCLES  = 80;
  localparam int              IDLE_LIMIT       = 2000;
  localparam int              DRAIN_CYCLES     = 8;
  localparam level_t          LEVEL_MAX        = '1;
  localparam logic [2:0]      OP_UNUSED_FIRST  = 3'd5;
  localparam logic [2:0]      OP_UNUSED_LAST   = 3'd7;
  localparam logic [ADDR_W-1:0] SAFE_RATIO_ADDR = ADDR_W'(REG_SAFE_RATIO) << 2;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic [2:0]        in_operation     = '0;
  level_t            in_target_level  = '0;
  level_t            in_bus_level     = '0;
  level_t            in_storage_level = '0;
  logic              out_stall        = 1'b0;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [ADDR_W-1:0] paddr            = '0;
  logic [DATA_W-1:0] pwdata           = '0;

  logic              in_stall;
  logic              out_valid;
  logic [2:0]        out_mode;
  logic              out_ess_discharge_closed;
  logic              out_discharge_closed;
  logic              out_ess_charge_closed;
  logic              out_low_side_closed;
  logic              out_high_side_closed;
  logic              out_precharge_closed;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  contactor_scoreboard sb = new();
  int                  results_seen = 0;

  precharge_contactor_sequencer_top dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_operation             (in_operation),
    .in_target_level          (in_target_level),
    .in_bus_level             (in_bus_level),
    .in_storage_level         (in_storage_level),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_mode                 (out_mode),
    .out_ess_discharge_closed (out_ess_discharge_closed),
    .out_discharge_closed     (out_discharge_closed),
    .out_ess_charge_closed    (out_ess_charge_closed),
    .out_low_side_closed      (out_low_side_closed),
    .out_high_side_closed     (out_high_side_closed),
    .out_precharge_closed     (out_precharge_closed),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task is entered right after a rising edge; signals change
  // by nonblocking assignment, and handshake values read after the edge are the
  // ones the block saw at that edge.
  // ---------------------------------------------------------------------------

  // Offer one transaction and hold it until it is taken, then advance the
  // predictor. Leave in_valid high so a following transaction goes out back to back.
  task automatic send_item(input logic [2:0] op, input level_t tgt, input level_t bus,
                           input level_t sto);
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_target_level  <= tgt;
    in_bus_level     <= bus;
    in_storage_level <= sto;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, tgt, bus, sto);
  endtask

  // Drop valid for a gap; callers never pass zero, so valid is not lowered and
  // raised again in one step.
  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  // Upper data bits carry noise since only the low ten bits are the ratio.
  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    logic [DATA_W-1:0] data;
    data               = DATA_W'($urandom);
    data[RATIO_W-1:0]  = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SAFE_RATIO_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_ratio(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold the input idle until every expected result is back, then let the
  // pipeline settle before touching the register.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random content. Operation weights follow the predicted mode so most
  // transactions push the sequence forward; a slice of pure noise (unused codes
  // included) and misplaced requests stay in the mix.
  // ---------------------------------------------------------------------------
  function automatic logic [2:0] choose_operation(mode_t m);
    int w_tick;
    int w_charge;
    int w_close;
    int w_hold;
    int r;
    if ($urandom_range(0, 99) < 8) return 3'($urandom_range(0, 7));
    case (m)
      MODE_OPEN: begin
        w_tick = 45; w_charge = 40; w_close = 5; w_hold = 5;
      end
      MODE_CHARGING: begin
        w_tick = 70; w_charge = 15; w_close = 5; w_hold = 5;
      end
      MODE_CHARGED: begin
        w_tick = 45; w_charge = 12; w_close = 30; w_hold = 5;
      end
      MODE_PRECHARGE: begin
        w_tick = 65; w_charge = 6; w_close = 6; w_hold = 15;
      end
      default: begin
        w_tick = 55; w_charge = 3; w_close = 2; w_hold = 30;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_tick) return OP_TICK;
    r -= w_tick;
    if (r < w_charge) return OP_CHARGE;
    r -= w_charge;
    if (r < w_close) return OP_CLOSE;
    r -= w_close;
    if (r < w_hold) return OP_HOLD;
    return OP_FORCE_OPEN;
  endfunction

  function automatic level_t pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEVEL_MAX;
      2:       return level_t'($urandom_range(0, 255));
      default: return level_t'($urandom);
    endcase
  endfunction

  // Storage lands just below, on, or just above the latched target most of the time.
  function automatic level_t pick_storage();
    level_t d;
    d = level_t'($urandom_range(1, 40));
    case ($urandom_range(0, 4))
      0, 1: begin
        if (sb.target >= d) return sb.target - d;
        return '0;
      end
      2, 3: begin
        if (LEVEL_MAX - sb.target >= d) return sb.target + d - 1'b1;
        return LEVEL_MAX;
      end
      default: return pick_level();
    endcase
  endfunction

  // Bus lands around the smallest safe value for the current ratio.
  function automatic level_t pick_bus(level_t sto);
    longint need;
    longint guess;
    need = longint'((64'(sto) * 64'(sb.ratio) + 64'd255) >> RATIO_FRAC);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        guess = need + longint'($urandom_range(0, 6)) - 3;
        if (guess < 0) return '0;
        if (guess > longint'(LEVEL_MAX)) return LEVEL_MAX;
        return level_t'(guess);
      end
      4:       return '0;
      5:       return LEVEL_MAX;
      6:       return sto;
      default: return pick_level();
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] op;
    level_t     sto;
    op = choose_operation(sb.mode);
    case (op)
      OP_TICK: begin
        sto = pick_storage();
        send_item(op, level_t'($urandom), pick_bus(sto), sto);
      end
      OP_CHARGE: send_item(op, pick_level(), level_t'($urandom), level_t'($urandom));
      default:   send_item(op, level_t'($urandom), level_t'($urandom), level_t'($urandom));
    endcase
  endtask

  // Bursts of random length with random gaps; now and then a long burst with no idling.
  task automatic run_random(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_random();
        sent++;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) pause_input(gap);
    end
  endtask

  // Walk every mode and transition but charged -> charging on reset ratio 230: misplaced
  // requests, unused codes, target replacement, exact safe boundary, force open while open.
  task automatic run_directed();
    send_item(OP_TICK, LEVEL_MAX, '0, '0);                 // no request: stay open
    send_item(OP_HOLD, '0, '0, '0);                        // hold ignored in open
    send_item(OP_CLOSE, '0, '0, '0);                       // close ignored in open
    send_item(OP_UNUSED_FIRST, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
    send_item(OP_UNUSED_LAST, '0, '0, '0);
    send_item(OP_CHARGE, LEVEL_MAX, '0, '0);
    send_item(OP_CHARGE, 16'd1000, '0, '0);                // new target replaces old
    send_item(OP_TICK, '0, '0, 16'd999);                   // open -> charging
    send_item(OP_CHARGE, 16'd2000, '0, '0);                // accepted while charging
    send_item(OP_TICK, '0, '0, 16'd1999);                  // still below target
    send_item(OP_TICK, '0, '0, 16'd2000);                  // charging -> charged
    send_item(OP_HOLD, '0, '0, '0);                        // hold ignored in charged
    send_item(OP_CLOSE, '0, '0, '0);
    send_item(OP_TICK, '0, 16'd229, 16'd256);              // one below safe: precharge
    send_item(OP_CHARGE, 16'd10, '0, '0);                  // ignored in precharge
    send_item(OP_CLOSE, '0, '0, '0);                       // ignored in precharge
    send_item(OP_TICK, '0, 16'd230, 16'd256);              // exactly safe: closed
    send_item(OP_HOLD, '0, '0, '0);
    send_item(OP_TICK, '0, '0, '0);                        // closed -> charged
    send_item(OP_CHARGE, '0, '0, '0);
    send_item(OP_CLOSE, '0, '0, '0);
    send_item(OP_TICK, '0, '0, '0);                        // target reached, safe: closed
    send_item(OP_FORCE_OPEN, '0, '0, '0);
    send_item(OP_FORCE_OPEN, '0, '0, '0);                  // open again, flags clear
    send_item(OP_CHARGE, LEVEL_MAX, '0, '0);
    send_item(OP_TICK, '0, '0, LEVEL_MAX);                 // open -> charged directly
    send_item(OP_CLOSE, '0, '0, '0);
    send_item(OP_TICK, '0, '0, 16'd1);                     // bus zero: precharge
    send_item(OP_HOLD, '0, '0, '0);
    send_item(OP_TICK, '0, LEVEL_MAX, '0);                 // hold wins over safe bus
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls on its own pattern, picked anew for each run of
  // random length, and once holds off long enough for the block to back up its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int  stall_pct;
    int  run_len;
    bit  pressure_done;
    pressure_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        run_len = $urandom_range(8, 64);
        repeat (run_len) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.mode                 = mode_t'(out_mode);
      got.ess_discharge_closed = out_ess_discharge_closed;
      got.discharge_closed     = out_discharge_closed;
      got.ess_charge_closed    = out_ess_charge_closed;
      got.low_side_closed      = out_low_side_closed;
      got.high_side_closed     = out_high_side_closed;
      got.precharge_closed     = out_precharge_closed;
      sb.check_result(got);
      results_seen++;
    end
  end

  // End the run if no transaction moves on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** precharge_contactor_sequencer_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed walk on the reset ratio, then random phases,
  // each on a new ratio written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [RATIO_W-1:0] ratio_sched [0:5];
    ratio_sched = '{10'd0, 10'd1023, 10'd256, RATIO_RESET, 10'd1, 10'd0};
    ratio_sched[5] = RATIO_W'($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    foreach (ratio_sched[i]) begin
      drain();
      write_ratio(ratio_sched[i]);
      run_random(RANDOM_PER_PHASE);
    end
    drain();
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("** precharge_contactor_sequencer_top: PASSED **");
    else
      $display("** precharge_contactor_sequencer_top: FAILED **");
    $finish;
  end

endmodule
